FILE: rtl/core/erp_pkg.sv
// ---------------------------------------------------------------------------
// erp_pkg: shared types and constants
// Command and status codes, register indexes, configuration struct and
// queue entry kinds and back-end states for the e-ink refresh region policy block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package erp_pkg;

  localparam int SCR_BITS  = 12;
  localparam int CFG_DW    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int AL_BITS   = 8;
  localparam int PCT_SCALE = 100;
  localparam logic [7:0] CNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_FULL = 2'd1,
    CMD_PART = 2'd2,
    CMD_STAT = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_IOERR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PS  = 3'd6;

  localparam logic [1:0] K_RECT  = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_OUT   = 2'd2;

  typedef struct packed {
    logic [SCR_BITS-1:0] sw;
    logic [SCR_BITS-1:0] sh;
    logic [AL_BITS-1:0]  ax;
    logic [AL_BITS-1:0]  ay;
    logic [7:0]          pct;
    logic [7:0]          fap;
    logic                ps;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SNAP,
    B_WAIT,
    B_AREA1,
    B_AREA2
  } bstate_e;

endpackage

FILE: rtl/core/erp_front.sv
// ---------------------------------------------------------------------------
// erp_front: input classification
// Sorts each transaction into rectangle, frame close or outcome, works out
// the exclusive edges and the status code, and drops empty open rectangles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module erp_front import erp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int EW = 2 + 1 + 2 + 4 * COORD_BITS + 2
) (
  input  logic                  in_valid_i,
  input  logic                  full_i,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] rect_x_i,
  input  logic [COORD_BITS-1:0] rect_y_i,
  input  logic [COORD_BITS-1:0] rect_w_i,
  input  logic [COORD_BITS-1:0] rect_h_i,
  input  logic                  last_rect_i,
  input  logic [1:0]            outcome_i,
  output logic                  push_o,
  output logic [EW-1:0]         data_o
);

  logic            empty;
  logic [1:0]      kind;
  logic [1:0]      status;
  logic [COORD_BITS:0] r_edge, b_edge;

  assign empty  = (rect_w_i == '0) || (rect_h_i == '0);
  assign r_edge = {1'b0, rect_x_i} + {1'b0, rect_w_i};
  assign b_edge = {1'b0, rect_y_i} + {1'b0, rect_h_i};

  always_comb begin
    case (outcome_i)
      2'd0:    status = ST_OK;
      2'd1:    status = ST_BUSY;
      default: status = ST_IOERR;
    endcase
    if (action_i) kind = K_OUT;
    else if (empty) kind = K_CLOSE;
    else kind = K_RECT;
  end

  assign push_o = in_valid_i && !full_i && !(!action_i && empty && !last_rect_i);
  assign data_o = {kind, last_rect_i, status, rect_x_i, rect_y_i, r_edge, b_edge};

endmodule

FILE: rtl/core/erp_queue.sv
// ---------------------------------------------------------------------------
// erp_queue: two-entry queue
// Decouples classification from execution.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module erp_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rp_q];

endmodule

FILE: rtl/core/erp_rem.sv
// ---------------------------------------------------------------------------
// erp_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; yields the remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module erp_rem import erp_pkg::*; #(
  parameter int DW = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dividend_i,
  input  logic [AL_BITS-1:0] divisor_i,
  output logic               done_o,
  output logic [AL_BITS-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]      dv_q;
  logic [AL_BITS-1:0] div_q, rem_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;
  logic [AL_BITS:0]   trial;
  logic [AL_BITS:0]   diff;

  assign trial = {rem_q, dv_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[DW-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, div_q}) ? diff[AL_BITS-1:0] : trial[AL_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/erp_back.sv
// ---------------------------------------------------------------------------
// erp_back: policy execution
// Holds the bounding box and refresh state, snaps and clips the box on a
// frame close, takes the refresh decision and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module erp_back import erp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int EW = 2 + 1 + 2 + 4 * COORD_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  q_valid_i,
  input  logic [EW-1:0]         q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            out_command_o,
  output logic [COORD_BITS-1:0] out_region_x_o,
  output logic [COORD_BITS-1:0] out_region_y_o,
  output logic [COORD_BITS-1:0] out_region_w_o,
  output logic [COORD_BITS-1:0] out_region_h_o,
  output logic [1:0]            out_status_o
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 2;
  localparam int CW  = (DW > SCR_BITS) ? DW : SCR_BITS;
  localparam int MW  = (2 * CB + 7 > 32) ? 2 * CB + 7 : 32;

  logic [1:0]    e_kind, e_status;
  logic          e_last;
  logic [CB-1:0] e_x, e_y;
  logic [CB:0]   e_r, e_b;

  assign {e_kind, e_last, e_status, e_x, e_y, e_r, e_b} = q_data_i;

  bstate_e       state_q, state_d;
  logic [CB-1:0] box_l_q, box_t_q;
  logic [CB:0]   box_r_q, box_b_q;
  logic          box_v_q;
  logic [7:0]    pc_q;
  cmd_e          pend_q;
  logic [1:0]    step_q;
  logic [DW-1:0] p0_q;
  logic [CB-1:0] rx_q, ry_q, rw_q, rh_q;
  logic [2*CB-1:0] dirty_q;
  logic [2*SCR_BITS-1:0] scr_q;
  logic          ov_q;
  logic [1:0]    ocmd_q, ost_q;
  logic [CB-1:0] ox_q, oy_q, ow_q, oh_q;

  logic               pop, rem_start, rem_done;
  logic [AL_BITS-1:0] al, rem;
  logic [DW-1:0]      d_sel, p_val, p1c;
  logic [SCR_BITS-1:0] lim;
  logic [CB-1:0]      len;
  logic [MW-1:0]      lhs, rhs;
  logic               area_full, count_full;
  cmd_e               dec;

  always_comb begin
    al  = step_q[1] ? cfg_i.ay : cfg_i.ax;
    if (al == '0) al = AL_BITS'(1);
    lim = step_q[1] ? cfg_i.sh : cfg_i.sw;
    case (step_q)
      2'd0:    d_sel = DW'(box_l_q);
      2'd1:    d_sel = DW'(box_r_q) + DW'(al) - DW'(1);
      2'd2:    d_sel = DW'(box_t_q);
      default: d_sel = DW'(box_b_q) + DW'(al) - DW'(1);
    endcase
    p_val = d_sel - DW'(rem);
    p1c   = (CW'(p_val) > CW'(lim)) ? DW'(lim) : p_val;
    len   = (p1c > p0_q) ? CB'(p1c - p0_q) : '0;
  end

  erp_rem #(.DW(DW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (d_sel),
    .divisor_i  (al),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign lhs = MW'(dirty_q) * MW'(PCT_SCALE);
  assign rhs = MW'(scr_q) * MW'(cfg_i.pct);
  assign area_full  = (scr_q != '0) && (lhs >= rhs);
  assign count_full = (cfg_i.fap != '0) && (pc_q >= cfg_i.fap);

  always_comb begin
    if (!cfg_i.ps || area_full || count_full) dec = CMD_FULL;
    else if (rw_q != '0 && rh_q != '0) dec = CMD_PART;
    else dec = CMD_NONE;
  end

  assign pop = (state_q == B_IDLE) && q_valid_i && !ov_q;

  always_comb begin
    state_d   = state_q;
    rem_start = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (pop && (e_kind == K_CLOSE || (e_kind == K_RECT && e_last))) state_d = B_SNAP;
      end
      B_SNAP: begin
        if (!box_v_q) state_d = B_AREA1;
        else begin
          rem_start = 1'b1;
          state_d   = B_WAIT;
        end
      end
      B_WAIT: begin
        if (rem_done) state_d = (step_q == 2'd3) ? B_AREA1 : B_SNAP;
      end
      B_AREA1: state_d = B_AREA2;
      B_AREA2: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      box_l_q <= '0;
      box_t_q <= '0;
      box_r_q <= '0;
      box_b_q <= '0;
      box_v_q <= 1'b0;
      pc_q    <= '0;
      pend_q  <= CMD_NONE;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          step_q <= '0;
          if (pop) begin
            if (e_kind == K_OUT) begin
              if (e_status == ST_OK) begin
                if (pend_q == CMD_FULL) pc_q <= '0;
                if (pend_q == CMD_PART && pc_q != CNT_MAX) pc_q <= pc_q + 8'd1;
                if (pend_q != CMD_NONE) box_v_q <= 1'b0;
              end
              pend_q <= CMD_NONE;
              ov_q   <= 1'b1;
            end else if (e_kind == K_RECT) begin
              box_v_q <= 1'b1;
              if (!box_v_q || e_x < box_l_q) box_l_q <= e_x;
              if (!box_v_q || e_y < box_t_q) box_t_q <= e_y;
              if (!box_v_q || e_r > box_r_q) box_r_q <= e_r;
              if (!box_v_q || e_b > box_b_q) box_b_q <= e_b;
            end
          end
        end
        B_WAIT: begin
          if (rem_done) step_q <= step_q + 2'd1;
        end
        B_AREA2: begin
          pend_q <= dec;
          if (dec == CMD_NONE) box_v_q <= 1'b0;
          ov_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_SNAP && !box_v_q) begin
      rx_q <= '0;
      ry_q <= '0;
      rw_q <= '0;
      rh_q <= '0;
    end
    if (state_q == B_WAIT && rem_done) begin
      case (step_q)
        2'd0:    p0_q <= p_val;
        2'd1:    begin rx_q <= CB'(p0_q); rw_q <= len; end
        2'd2:    p0_q <= p_val;
        default: begin ry_q <= CB'(p0_q); rh_q <= len; end
      endcase
    end
    if (state_q == B_AREA1) begin
      dirty_q <= rw_q * rh_q;
      scr_q   <= cfg_i.sw * cfg_i.sh;
    end
    if (pop && e_kind == K_OUT) begin
      ocmd_q <= CMD_STAT;
      ost_q  <= e_status;
      ox_q   <= '0;
      oy_q   <= '0;
      ow_q   <= '0;
      oh_q   <= '0;
    end
    if (state_q == B_AREA2) begin
      ocmd_q <= dec;
      ost_q  <= ST_OK;
      ox_q   <= rx_q;
      oy_q   <= ry_q;
      ow_q   <= rw_q;
      oh_q   <= rh_q;
    end
  end

  assign q_pop_o        = pop;
  assign out_valid_o    = ov_q;
  assign out_command_o  = ocmd_q;
  assign out_region_x_o = ox_q;
  assign out_region_y_o = oy_q;
  assign out_region_w_o = ow_q;
  assign out_region_h_o = oh_q;
  assign out_status_o   = ost_q;

endmodule

FILE: rtl/core/eink_refresh_region_policy_top.sv
// ---------------------------------------------------------------------------
// eink_refresh_region_policy_top: e-ink refresh region policy
// Grows a dirty bounding box per frame and decides full, partial or no
// refresh; outcome transactions update the partial refresh count.
// ---------------------------------------------------------------------------
// A frame close runs the one-bit-per-cycle remainder unit that snaps the four
// box edges in turn when the box is valid. Transactions are carried out
// strictly in order, one at a time, with a two-entry queue in front.
`timescale 1ns / 1ps
module eink_refresh_region_policy_top import erp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DW-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_action_i,
  input  logic [COORD_BITS-1:0] in_rect_x_i,
  input  logic [COORD_BITS-1:0] in_rect_y_i,
  input  logic [COORD_BITS-1:0] in_rect_w_i,
  input  logic [COORD_BITS-1:0] in_rect_h_i,
  input  logic                  in_last_rect_i,
  input  logic [1:0]            in_outcome_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            out_command_o,
  output logic [COORD_BITS-1:0] out_region_x_o,
  output logic [COORD_BITS-1:0] out_region_y_o,
  output logic [COORD_BITS-1:0] out_region_w_o,
  output logic [COORD_BITS-1:0] out_region_h_o,
  output logic [1:0]            out_status_o
);

  localparam int EW = 2 + 1 + 2 + 4 * COORD_BITS + 2;

  cfg_t          cfg_q;
  logic          push, full, q_valid, pop;
  logic [EW-1:0] f_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sw  <= 12'd800;
      cfg_q.sh  <= 12'd480;
      cfg_q.ax  <= 8'd8;
      cfg_q.ay  <= 8'd1;
      cfg_q.pct <= 8'd50;
      cfg_q.fap <= 8'd10;
      cfg_q.ps  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SW:  cfg_q.sw  <= cfg_data_i;
        CFG_SH:  cfg_q.sh  <= cfg_data_i;
        CFG_AX:  cfg_q.ax  <= cfg_data_i[7:0];
        CFG_AY:  cfg_q.ay  <= cfg_data_i[7:0];
        CFG_PCT: cfg_q.pct <= cfg_data_i[7:0];
        CFG_FAP: cfg_q.fap <= cfg_data_i[7:0];
        CFG_PS:  cfg_q.ps  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;

  erp_front #(.COORD_BITS(COORD_BITS), .EW(EW)) u_front (
    .in_valid_i  (in_valid_i),
    .full_i      (full),
    .action_i    (in_action_i),
    .rect_x_i    (in_rect_x_i),
    .rect_y_i    (in_rect_y_i),
    .rect_w_i    (in_rect_w_i),
    .rect_h_i    (in_rect_h_i),
    .last_rect_i (in_last_rect_i),
    .outcome_i   (in_outcome_i),
    .push_o      (push),
    .data_o      (f_data)
  );

  erp_queue #(.W(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_data),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (full),
    .data_o  (q_data)
  );

  erp_back #(.COORD_BITS(COORD_BITS), .EW(EW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_command_o  (out_command_o),
    .out_region_x_o (out_region_x_o),
    .out_region_y_o (out_region_y_o),
    .out_region_w_o (out_region_w_o),
    .out_region_h_o (out_region_h_o),
    .out_status_o   (out_status_o)
  );

endmodule

FILE: rtl/core/erp_checker.sv
// ---------------------------------------------------------------------------
// erp_checker: port-level checks
// Result channel checks on the top level, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module erp_checker import erp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            out_command_o,
  input logic [COORD_BITS-1:0] out_region_x_o,
  input logic [COORD_BITS-1:0] out_region_y_o,
  input logic [COORD_BITS-1:0] out_region_w_o,
  input logic [COORD_BITS-1:0] out_region_h_o,
  input logic [1:0]            out_status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_command_o == CMD_STAT |->
      out_region_x_o == '0 && out_region_y_o == '0 &&
      out_region_w_o == '0 && out_region_h_o == '0)
    else $error("status result carries a region");

  a_dec_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_command_o != CMD_STAT |-> out_status_o == ST_OK)
    else $error("decision result carries a status");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_command_o == CMD_NONE |->
      out_region_w_o == '0 || out_region_h_o == '0)
    else $error("no refresh with a non-empty region");

endmodule

bind eink_refresh_region_policy_top erp_checker #(.COORD_BITS(COORD_BITS)) u_erp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_command_o  (out_command_o),
  .out_region_x_o (out_region_x_o),
  .out_region_y_o (out_region_y_o),
  .out_region_w_o (out_region_w_o),
  .out_region_h_o (out_region_h_o),
  .out_status_o   (out_status_o)
);
